>>> src/gpe_pkg.sv
package gpe_pkg;

	// Size limits and field widths
	localparam int MAX_ELEMENTS_DEF = 16;
	localparam int ELEM_W           = 4;
	localparam int ARR_W            = 64;
	localparam int COUNT_W          = 5;
	localparam int MASK_W           = 16;
	localparam int CFG_W            = 16;
	localparam int CFG_IDX_W        = 2;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_ELEMENT_COUNT  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_GROUP_END_MASK = 2'd1;

	// Command codes; the unused code behaves as load
	localparam logic [1:0] ACT_ADVANCE = 2'd0;
	localparam logic [1:0] ACT_RESTART = 2'd1;
	localparam logic [1:0] ACT_LOAD    = 2'd2;

	// Status codes
	localparam logic [1:0] ST_ADVANCED  = 2'd0;
	localparam logic [1:0] ST_WRAPPED   = 2'd1;
	localparam logic [1:0] ST_RESTARTED = 2'd2;
	localparam logic [1:0] ST_LOADED    = 2'd3;

	typedef struct packed {
		logic [1:0]       action;
		logic [ARR_W-1:0] load_value;
	} cmd_t;

	typedef struct packed {
		logic [ARR_W-1:0] arrangement;
		logic [1:0]       status;
	} rsp_t;

	// Store write controls from the sequencer
	typedef struct packed {
		logic swap_we;
		logic load;
	} wr_ctl_t;

	// Sequencer status toward the top level
	typedef struct packed {
		logic       idle;
		logic       done;
		logic [1:0] status;
	} seq_stat_t;

endpackage

>>> src/gpe_store.sv
module gpe_store import gpe_pkg::*; #(
	parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF,
	parameter int IDX_W        = $clog2(MAX_ELEMENTS)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  wr_ctl_t           wr,
	input  logic [ARR_W-1:0]  load_value,
	input  logic [IDX_W-1:0]  wa0,
	input  logic [ELEM_W-1:0] wd0,
	input  logic [IDX_W-1:0]  wa1,
	input  logic [ELEM_W-1:0] wd1,
	input  logic [IDX_W-1:0]  rd_addr,
	output logic [ELEM_W-1:0] rd_data,
	output logic [ARR_W-1:0]  arr_flat
);

	logic [ELEM_W-1:0] arr_q [MAX_ELEMENTS];

	// Two write ports for a swap; load overwrites every entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < MAX_ELEMENTS; k++) begin
				arr_q[k] <= ELEM_W'(k);
			end
		end else begin
			for (int k = 0; k < MAX_ELEMENTS; k++) begin
				if (wr.load) begin
					arr_q[k] <= load_value[ELEM_W*k +: ELEM_W];
				end else if (wr.swap_we && wa1 == IDX_W'(k)) begin
					arr_q[k] <= wd1;
				end else if (wr.swap_we && wa0 == IDX_W'(k)) begin
					arr_q[k] <= wd0;
				end
			end
		end
	end

	assign rd_data = arr_q[rd_addr];

	always_comb begin
		arr_flat = '0;
		for (int k = 0; k < MAX_ELEMENTS; k++) begin
			arr_flat[ELEM_W*k +: ELEM_W] = arr_q[k];
		end
	end

endmodule

>>> src/gpe_ctrl.sv
module gpe_ctrl import gpe_pkg::*; #(
	parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF,
	parameter int IDX_W        = $clog2(MAX_ELEMENTS)
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic [1:0]              action,
	input  logic [COUNT_W-1:0]      element_count,
	input  logic [MAX_ELEMENTS-1:0] group_end,
	input  logic                    rsp_free,
	output logic [IDX_W-1:0]        rd_addr,
	input  logic [ELEM_W-1:0]       rd_data,
	output wr_ctl_t                 wr,
	output logic [IDX_W-1:0]        wa0,
	output logic [ELEM_W-1:0]       wd0,
	output logic [IDX_W-1:0]        wa1,
	output logic [ELEM_W-1:0]       wd1,
	output seq_stat_t               stat,
	output logic [IDX_W-1:0]        n_last
);

	typedef enum logic [8:0] {
		S_IDLE   = 9'b000000001,
		S_SEEK   = 9'b000000010,
		S_PIV    = 9'b000000100,
		S_FINDJ  = 9'b000001000,
		S_REV_A  = 9'b000010000,
		S_REV_B  = 9'b000100000,
		S_BSTART = 9'b001000000,
		S_BSTEP  = 9'b010000000,
		S_FIN    = 9'b100000000
	} state_t;

	state_t state_q, state_d;
	logic [IDX_W-1:0]  lo_q, lo_d, hi_q, hi_d;
	logic [IDX_W-1:0]  ptr_q, ptr_d, ptr2_q, ptr2_d, pividx_q, pividx_d;
	logic [IDX_W-1:0]  n_last_q, n_last_d;
	logic [ELEM_W-1:0] hold_q, hold_d;
	logic              wrap_q, wrap_d, swapped_q, swapped_d;
	logic [1:0]        status_q, status_d;

	logic [IDX_W-1:0]  nl_sat, step_nxt;
	logic [ELEM_W-1:0] op_a, op_b;
	logic              a_gt_b, ends, any_swap;

	// count saturated to 1..MAX_ELEMENTS, kept as last index
	always_comb begin
		if (element_count == '0) begin
			nl_sat = '0;
		end else if (element_count > COUNT_W'(MAX_ELEMENTS)) begin
			nl_sat = IDX_W'(MAX_ELEMENTS - 1);
		end else begin
			nl_sat = IDX_W'(element_count - 1'b1);
		end
	end

	// shared comparator
	assign op_a   = (state_q == S_FINDJ) ? rd_data : hold_q;
	assign op_b   = (state_q == S_FINDJ) ? hold_q  : rd_data;
	assign a_gt_b = op_a > op_b;

	assign ends     = (ptr_q == n_last_q) || group_end[ptr_q];
	assign step_nxt = ptr_q + 1'b1;
	assign any_swap = swapped_q || a_gt_b;

	always_comb begin
		state_d   = state_q;
		lo_d      = lo_q;
		hi_d      = hi_q;
		ptr_d     = ptr_q;
		ptr2_d    = ptr2_q;
		pividx_d  = pividx_q;
		n_last_d  = n_last_q;
		hold_d    = hold_q;
		wrap_d    = wrap_q;
		swapped_d = swapped_q;
		status_d  = status_q;
		rd_addr   = ptr_q;
		wr        = '0;
		wa0       = ptr_q;
		wd0       = rd_data;
		wa1       = ptr2_q;
		wd1       = hold_q;

		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					n_last_d = nl_sat;
					unique case (action)
						ACT_ADVANCE: begin
							lo_d    = '0;
							ptr_d   = '0;
							state_d = S_SEEK;
						end
						ACT_RESTART: begin
							status_d = ST_RESTARTED;
							ptr2_d   = nl_sat;
							state_d  = (nl_sat == '0) ? S_FIN : S_BSTART;
						end
						default: begin
							wr.load  = 1'b1;
							status_d = ST_LOADED;
							state_d  = S_FIN;
						end
					endcase
				end
			end
			// walk up to the end of the current group
			S_SEEK: begin
				hold_d = rd_data;
				if (ends) begin
					hi_d = ptr_q;
					if (ptr_q == lo_q) begin
						// one-element group always wraps
						if (ptr_q == n_last_q) begin
							status_d = ST_WRAPPED;
							state_d  = S_FIN;
						end else begin
							lo_d  = step_nxt;
							ptr_d = step_nxt;
						end
					end else begin
						ptr_d   = ptr_q - 1'b1;
						state_d = S_PIV;
					end
				end else begin
					ptr_d = step_nxt;
				end
			end
			// pivot: rightmost element smaller than its right neighbor
			S_PIV: begin
				hold_d = rd_data;
				if (a_gt_b) begin
					pividx_d = ptr_q;
					ptr_d    = hi_q;
					state_d  = S_FINDJ;
				end else if (ptr_q == lo_q) begin
					// non-increasing group: reversing it sorts it
					wrap_d  = 1'b1;
					ptr_d   = lo_q;
					ptr2_d  = hi_q;
					state_d = S_REV_A;
				end else begin
					ptr_d = ptr_q - 1'b1;
				end
			end
			// rightmost element above the pivot, then swap
			S_FINDJ: begin
				if (a_gt_b) begin
					wr.swap_we = 1'b1;
					wa0        = pividx_q;
					wd0        = rd_data;
					wa1        = ptr_q;
					wd1        = hold_q;
					wrap_d     = 1'b0;
					ptr_d      = pividx_q + 1'b1;
					ptr2_d     = hi_q;
					state_d    = S_REV_A;
				end else begin
					ptr_d = ptr_q - 1'b1;
				end
			end
			S_REV_A: begin
				if (ptr_q < ptr2_q) begin
					hold_d  = rd_data;
					state_d = S_REV_B;
				end else if (!wrap_q) begin
					status_d = ST_ADVANCED;
					state_d  = S_FIN;
				end else if (hi_q == n_last_q) begin
					status_d = ST_WRAPPED;
					state_d  = S_FIN;
				end else begin
					lo_d    = hi_q + 1'b1;
					ptr_d   = hi_q + 1'b1;
					state_d = S_SEEK;
				end
			end
			S_REV_B: begin
				rd_addr    = ptr2_q;
				wr.swap_we = 1'b1;
				ptr_d      = step_nxt;
				ptr2_d     = ptr2_q - 1'b1;
				state_d    = S_REV_A;
			end
			// bubble pass: hold carries the larger value rightward
			S_BSTART: begin
				rd_addr   = '0;
				hold_d    = rd_data;
				ptr_d     = '0;
				swapped_d = 1'b0;
				state_d   = S_BSTEP;
			end
			S_BSTEP: begin
				rd_addr = step_nxt;
				wa1     = step_nxt;
				if (a_gt_b) begin
					wr.swap_we = 1'b1;
				end else begin
					hold_d = rd_data;
				end
				ptr_d     = step_nxt;
				swapped_d = any_swap;
				if (step_nxt == ptr2_q) begin
					if (!any_swap || ptr2_q == IDX_W'(1)) begin
						state_d = S_FIN;
					end else begin
						ptr2_d  = ptr2_q - 1'b1;
						state_d = S_BSTART;
					end
				end
			end
			S_FIN: begin
				if (rsp_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		lo_q      <= lo_d;
		hi_q      <= hi_d;
		ptr_q     <= ptr_d;
		ptr2_q    <= ptr2_d;
		pividx_q  <= pividx_d;
		n_last_q  <= n_last_d;
		hold_q    <= hold_d;
		wrap_q    <= wrap_d;
		swapped_q <= swapped_d;
		status_q  <= status_d;
	end

	assign stat.idle   = (state_q == S_IDLE);
	assign stat.done   = (state_q == S_FIN) && rsp_free;
	assign stat.status = status_q;
	assign n_last      = n_last_q;

endmodule

>>> src/grouped_permutation_enumerator_unit.sv
// Throughput: one command at a time; cmd_ready is high only while the sequencer idles.
//   The single store read port and the one shared 4-bit comparator set the run time.
// Reset (arst_n low, asynchronous): identity arrangement, element_count 16,
//   group_end_mask 0x8000, no result pending.
module grouped_permutation_enumerator_unit import gpe_pkg::*; #(
	parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cmd_valid,
	output logic                 cmd_ready,
	input  cmd_t                 cmd,
	output logic                 rsp_valid,
	input  logic                 rsp_ready,
	output rsp_t                 rsp,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	localparam int IDX_W = $clog2(MAX_ELEMENTS);

	// Configuration registers, to be written only while idle (the block does not enforce this)
	logic [COUNT_W-1:0] element_count_q;
	logic [MASK_W-1:0]  group_end_mask_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			element_count_q  <= COUNT_W'(16);
			group_end_mask_q <= 16'h8000;
		end else if (cfg_we) begin
			if (cfg_index == CFG_ELEMENT_COUNT) begin
				element_count_q <= cfg_data[COUNT_W-1:0];
			end else if (cfg_index == CFG_GROUP_END_MASK) begin
				group_end_mask_q <= cfg_data[MASK_W-1:0];
			end
		end
	end

	// Sequencer <-> store
	wr_ctl_t           wr;
	logic [IDX_W-1:0]  rd_addr, wa0, wa1, n_last;
	logic [ELEM_W-1:0] rd_data, wd0, wd1;
	logic [ARR_W-1:0]  arr_flat, arr_masked;
	seq_stat_t         stat;
	logic              start, rsp_free;

	// Output register frees the sequencer from the consumer: a finished
	// result waits here while the next command is taken and worked on.
	logic rsp_valid_q;
	rsp_t rsp_q;

	assign cmd_ready = stat.idle;
	assign start     = cmd_valid && cmd_ready;
	assign rsp_free  = !rsp_valid_q || rsp_ready;

	gpe_ctrl #(
		.MAX_ELEMENTS (MAX_ELEMENTS),
		.IDX_W        (IDX_W)
	) u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.action        (cmd.action),
		.element_count (element_count_q),
		.group_end     (group_end_mask_q[MAX_ELEMENTS-1:0]),
		.rsp_free      (rsp_free),
		.rd_addr       (rd_addr),
		.rd_data       (rd_data),
		.wr            (wr),
		.wa0           (wa0),
		.wd0           (wd0),
		.wa1           (wa1),
		.wd1           (wd1),
		.stat          (stat),
		.n_last        (n_last)
	);

	gpe_store #(
		.MAX_ELEMENTS (MAX_ELEMENTS),
		.IDX_W        (IDX_W)
	) u_store (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr         (wr),
		.load_value (cmd.load_value),
		.wa0        (wa0),
		.wd0        (wd0),
		.wa1        (wa1),
		.wd1        (wd1),
		.rd_addr    (rd_addr),
		.rd_data    (rd_data),
		.arr_flat   (arr_flat)
	);

	// Elements past the in-use count read as zero in the result
	always_comb begin
		arr_masked = '0;
		for (int k = 0; k < MAX_ELEMENTS; k++) begin
			if (IDX_W'(k) <= n_last) begin
				arr_masked[ELEM_W*k +: ELEM_W] = arr_flat[ELEM_W*k +: ELEM_W];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (stat.done) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// payload captured on the same edge the sequencer finishes
	always_ff @(posedge clk) begin
		if (stat.done) begin
			rsp_q.arrangement <= arr_masked;
			rsp_q.status      <= stat.status;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

>>> src/gpe_checker.sv
module gpe_checker import gpe_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic cmd_valid,
	input logic cmd_ready,
	input cmd_t cmd,
	input logic rsp_valid,
	input logic rsp_ready,
	input rsp_t rsp
);

	// stalled result holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("rsp changed while stalled");

	// one command in work at a time
	a_busy_after_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready |=> !cmd_ready)
		else $error("cmd_ready high right after a cmd transfer");

	// a new result only comes out of a busy sequencer
	a_rsp_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(!cmd_ready))
		else $error("result appeared while idle");

	// a load with no result pending answers with status loaded and the loaded first element
	a_load_result: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready && cmd.action[1] && !rsp_valid |=> ##1
		rsp_valid && rsp.status == ST_LOADED &&
		rsp.arrangement[ELEM_W-1:0] == $past(cmd.load_value[ELEM_W-1:0], 2))
		else $error("load result wrong or late");

endmodule

bind grouped_permutation_enumerator_unit gpe_checker u_gpe_checker (.*);

>>> tb/sv/grouped_permutation_enumerator_unit_tb.sv
module grouped_permutation_enumerator_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import gpe_pkg::*;

	// Spare command code; the block treats it as a load
	localparam logic [1:0] ACT_SPARE = 2'd3;

	// Cycles with no transfer on either channel before the run is abandoned.
	// The limit covers the slowest legal command (restart at 16 elements), plus the
	// longest sender gap and the longest response stall.
	localparam int WATCHDOG_LIMIT = 4000;
	// Worst-case command latency, waited out once at the end of the run
	localparam int LATENCY_MAX    = 200;
	// Mismatch lines printed before going quiet (all are still counted)
	localparam int PRINT_CAP      = 40;

	// DUT connections, every input known from time zero
	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 cmd_valid = 1'b0;
	logic                 cmd_ready;
	cmd_t                 cmd       = '0;
	logic                 rsp_valid;
	logic                 rsp_ready = 1'b0;
	rsp_t                 rsp;
	logic                 cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = CFG_ELEMENT_COUNT;
	logic [CFG_W-1:0]     cfg_data  = '0;

	// Shadow copy of the block: stored arrangement and both registers
	logic [ELEM_W-1:0]  perm_model [MAX_ELEMENTS_DEF];
	logic [COUNT_W-1:0] count_model;
	logic [MASK_W-1:0]  mask_model;

	// Predicted answers, oldest first
	rsp_t answer_q [$];

	int  mismatches  = 0;
	int  n_sent      = 0;
	int  n_advanced  = 0;
	int  n_wrapped   = 0;
	int  n_restarted = 0;
	int  n_loaded    = 0;
	int  n_settings  = 0;
	int  idle_run    = 0;
	int  stall_left  = 0;
	// When set, no sender gaps and no response stalls
	bit  steady      = 1'b0;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	grouped_permutation_enumerator_unit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// ------------------------------------------------------------------
	// Arrangement predictor
	// ------------------------------------------------------------------

	function automatic void model_reset();
		for (int i = 0; i < MAX_ELEMENTS_DEF; i++) perm_model[i] = ELEM_W'(i);
		count_model = COUNT_W'(16);
		mask_model  = 16'h8000;
	endfunction

	// Element count in use: register saturated to 1..16
	function automatic int live_len();
		if (count_model == 0) return 1;
		if (count_model > MAX_ELEMENTS_DEF) return MAX_ELEMENTS_DEF;
		return int'(count_model);
	endfunction

	function automatic void swap_pair(int a, int b);
		logic [ELEM_W-1:0] t;
		t             = perm_model[a];
		perm_model[a] = perm_model[b];
		perm_model[b] = t;
	endfunction

	// Insertion sort of entries lo..hi; stable for repeated values
	function automatic void sort_group(int lo, int hi);
		int j;
		for (int i = lo + 1; i <= hi; i++) begin
			j = i;
			while (j > lo && perm_model[j-1] > perm_model[j]) begin
				swap_pair(j - 1, j);
				j--;
			end
		end
	endfunction

	// Lexicographic successor of entries lo..hi; 0 when already in last order
	function automatic bit next_in_group(int lo, int hi);
		int i;
		int j;
		int a;
		int b;
		if (hi <= lo) return 1'b0;
		// pivot: rightmost i with entry[i] < entry[i+1]
		i = hi - 1;
		while (i >= lo && perm_model[i] >= perm_model[i+1]) i--;
		if (i < lo) return 1'b0;
		j = hi;
		while (perm_model[j] <= perm_model[i]) j--;
		swap_pair(i, j);
		a = i + 1;
		b = hi;
		while (a < b) begin
			swap_pair(a, b);
			a++;
			b--;
		end
		return 1'b1;
	endfunction

	// Apply one command to the shadow state and form the answer it gives
	function automatic rsp_t apply_command(cmd_t c);
		rsp_t r;
		int   n;
		int   first;
		bit   stepped;
		n = live_len();
		r = '0;
		case (c.action)
			ACT_ADVANCE: begin
				// odometer: first group that can step wins, wrapped groups go back to sorted
				stepped = 1'b0;
				first   = 0;
				for (int i = 0; i < n && !stepped; i++) begin
					if (i == n - 1 || mask_model[i]) begin
						if (next_in_group(first, i)) begin
							stepped = 1'b1;
						end else begin
							sort_group(first, i);
							first = i + 1;
						end
					end
				end
				r.status = stepped ? ST_ADVANCED : ST_WRAPPED;
			end
			ACT_RESTART: begin
				sort_group(0, n - 1);
				r.status = ST_RESTARTED;
			end
			ACT_LOAD, ACT_SPARE: begin
				// all entries written, also the ones beyond the count
				for (int i = 0; i < MAX_ELEMENTS_DEF; i++)
					perm_model[i] = c.load_value[ELEM_W*i +: ELEM_W];
				r.status = ST_LOADED;
			end
		endcase
		// only in-use elements show up, the rest of the word is zero
		for (int i = 0; i < n; i++) r.arrangement[ELEM_W*i +: ELEM_W] = perm_model[i];
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------

	// Mostly short gaps, a few long ones
	function automatic int pick_gap();
		int r;
		if (steady) return 0;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Permutation of 0..n-1 in the live entries, random nibbles above.
	// near_last puts each group in descending order so the next advance wraps it.
	function automatic logic [ARR_W-1:0] perm_word(bit near_last);
		logic [ELEM_W-1:0] e [MAX_ELEMENTS_DEF];
		logic [ELEM_W-1:0] t;
		logic [ARR_W-1:0]  w;
		int                n;
		int                k;
		int                first;
		n = live_len();
		for (int i = 0; i < MAX_ELEMENTS_DEF; i++)
			e[i] = (i < n) ? ELEM_W'(i) : ELEM_W'($urandom);
		for (int i = n - 1; i > 0; i--) begin
			k    = $urandom_range(0, i);
			t    = e[i];
			e[i] = e[k];
			e[k] = t;
		end
		if (near_last) begin
			first = 0;
			for (int i = 0; i < n; i++) begin
				if (i == n - 1 || mask_model[i]) begin
					for (int a = first; a < i; a++)
						for (int b = a + 1; b <= i; b++)
							if (e[b] > e[a]) begin
								t    = e[a];
								e[a] = e[b];
								e[b] = t;
							end
					first = i + 1;
				end
			end
		end
		w = '0;
		for (int i = 0; i < MAX_ELEMENTS_DEF; i++) w[ELEM_W*i +: ELEM_W] = e[i];
		return w;
	endfunction

	// One command transfer; the prediction is taken at the accepting edge.
	// Valid is left high so a following zero-gap command reuses it without a drop.
	task automatic send_cmd(logic [1:0] act, logic [ARR_W-1:0] word);
		int   gap;
		cmd_t c;
		gap          = pick_gap();
		c.action     = act;
		c.load_value = word;
		if (gap > 0) begin
			cmd_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd       <= c;
		cmd_valid <= 1'b1;
		@(posedge clk);
		while (!cmd_ready) @(posedge clk);
		answer_q.push_back(apply_command(c));
		n_sent++;
	endtask

	// Drop valid, wait for every outstanding answer, then some quiet cycles
	task automatic settle(int extra);
		cmd_valid <= 1'b0;
		while (answer_q.size() != 0) @(posedge clk);
		repeat (extra) @(posedge clk);
	endtask

	task automatic wr_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
		cfg_index <= idx;
		cfg_data  <= data;
		cfg_we    <= 1'b1;
		@(posedge clk);
		if (idx == CFG_ELEMENT_COUNT) count_model = data[COUNT_W-1:0];
		else if (idx == CFG_GROUP_END_MASK) mask_model = data[MASK_W-1:0];
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// Registers only change with the block idle
	task automatic set_config(logic [CFG_W-1:0] count_word, logic [CFG_W-1:0] mask_word);
		settle(4);
		wr_reg(CFG_ELEMENT_COUNT, count_word);
		wr_reg(CFG_GROUP_END_MASK, mask_word);
		n_settings++;
	endtask

	// Random command mix: advance-heavy, well-formed loads mostly, some junk words
	task automatic send_random();
		int r;
		bit near;
		r    = $urandom_range(0, 99);
		near = ($urandom_range(0, 2) == 0);
		if (r < 62) send_cmd(ACT_ADVANCE, {$urandom, $urandom});
		else if (r < 72) send_cmd(ACT_RESTART, {$urandom, $urandom});
		else if (r < 86) send_cmd(ACT_LOAD, perm_word(near));
		else if (r < 94) send_cmd(ACT_LOAD, {$urandom, $urandom});
		else if (near) send_cmd(ACT_SPARE, perm_word(1'b0));
		else send_cmd(ACT_SPARE, {$urandom, $urandom});
	endtask

	// Count mostly small (wraps come often there), sometimes 0/1 or above 16
	task automatic random_config();
		int                 r;
		logic [COUNT_W-1:0] cnt;
		logic [CFG_W-1:0]   cnt_word;
		logic [MASK_W-1:0]  m;
		r = $urandom_range(0, 99);
		if (r < 40) cnt = COUNT_W'($urandom_range(2, 5));
		else if (r < 65) cnt = COUNT_W'($urandom_range(6, 10));
		else if (r < 80) cnt = COUNT_W'($urandom_range(11, 16));
		else if (r < 90) cnt = COUNT_W'($urandom_range(0, 1));
		else cnt = COUNT_W'($urandom_range(17, 31));
		// upper bits of the count write are don't-care; toggle them anyway
		cnt_word                = CFG_W'($urandom);
		cnt_word[COUNT_W-1:0]   = cnt;
		r = $urandom_range(0, 9);
		if (r == 0) m = '0;
		else if (r == 1) m = '1;
		else m = MASK_W'($urandom);
		set_config(cnt_word, m);
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Out of reset: 16 elements, one group, identity order
	task automatic test_reset_defaults();
		send_cmd(ACT_ADVANCE, '0);
		send_cmd(ACT_ADVANCE, '1);
		send_cmd(ACT_RESTART, '0);
	endtask

	// Last order wraps to sorted; repeated values; spare code loads
	task automatic test_wrap_and_duplicates();
		send_cmd(ACT_LOAD, 64'h0123_4567_89AB_CDEF);   // fully descending
		send_cmd(ACT_ADVANCE, '0);
		send_cmd(ACT_LOAD, 64'hFFFF_FFFF_FFFF_FFFF);   // all equal
		send_cmd(ACT_ADVANCE, '0);
		send_cmd(ACT_SPARE, 64'hFEDC_BA98_7654_3210);  // identity through the spare code
		send_cmd(ACT_LOAD, 64'h1111_0000_2222_3333);   // multiset
		send_cmd(ACT_ADVANCE, '0);
		send_cmd(ACT_RESTART, '0);
	endtask

	// Count 0 acts as 1, count above 16 acts as 16
	task automatic test_count_extremes();
		set_config(16'hFFE0, 16'h0000);
		send_cmd(ACT_ADVANCE, '0);
		send_cmd(ACT_RESTART, '0);
		send_cmd(ACT_LOAD, 64'hFFFF_FFFF_FFFF_FFFF);
		send_cmd(ACT_ADVANCE, '0);
		// every element its own group: nothing can step
		set_config(16'h001F, 16'hFFFF);
		send_cmd(ACT_ADVANCE, '0);
		set_config(16'h0011, 16'h0000);
		send_cmd(ACT_ADVANCE, '0);
	endtask

	// Two groups of three; mask bits past the count are ignored
	task automatic test_group_boundaries();
		set_config(16'd6, 16'h0004);
		send_cmd(ACT_LOAD, 64'h0000_0000_0054_3012);   // first group last order, second first
		send_cmd(ACT_ADVANCE, '0);
		set_config(16'd4, 16'hFFF0);
		send_cmd(ACT_RESTART, '0);
		send_cmd(ACT_ADVANCE, '0);
	endtask

	// Entries beyond the count survive advance and restart
	task automatic test_hidden_entries();
		set_config(16'd4, 16'h0000);
		send_cmd(ACT_LOAD, 64'h9C3A_57E1_0246_8BDF);
		send_cmd(ACT_ADVANCE, '0);
		send_cmd(ACT_RESTART, '0);
		set_config(16'h0010, 16'h8000);
		send_cmd(ACT_ADVANCE, '0);
	endtask

	task automatic test_random_phases();
		for (int p = 0; p < 11; p++) begin
			random_config();
			repeat (100) send_random();
		end
	endtask

	// Full throughput: no sender gaps, no response stalls
	task automatic test_back_to_back();
		set_config(16'd16, MASK_W'($urandom));
		steady = 1'b1;
		repeat (100) send_random();
		settle(4);
		steady = 1'b0;
	endtask

	// ------------------------------------------------------------------
	// Response side
	// ------------------------------------------------------------------

	// Random backpressure; held high throughout while steady
	always @(posedge clk) begin
		if (arst_n) begin
			if (steady) begin
				rsp_ready <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				rsp_ready <= 1'b0;
			end else if ($urandom_range(0, 3) != 0) begin
				rsp_ready <= 1'b1;
			end else begin
				stall_left = pick_gap();
				rsp_ready <= 1'b0;
			end
		end
	end

	task automatic flag_mismatch(string what, logic [ARR_W-1:0] got, logic [ARR_W-1:0] want);
		if (mismatches < PRINT_CAP)
			$display("%0t ns: mismatch on %s: got %h, want %h", $time, what, got, want);
		mismatches++;
	endtask

	// Every response transfer is checked against the oldest prediction
	always @(posedge clk) begin : check_rsp
		rsp_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (answer_q.size() == 0) begin
				flag_mismatch("response with nothing outstanding", rsp.arrangement, '0);
			end else begin
				want = answer_q.pop_front();
				if (rsp.arrangement !== want.arrangement)
					flag_mismatch("arrangement", rsp.arrangement, want.arrangement);
				if (rsp.status !== want.status)
					flag_mismatch("status", ARR_W'(rsp.status), ARR_W'(want.status));
				case (want.status)
					ST_ADVANCED:  n_advanced++;
					ST_WRAPPED:   n_wrapped++;
					ST_RESTARTED: n_restarted++;
					ST_LOADED:    n_loaded++;
				endcase
			end
		end
	end

	// Watchdog: too long without any transfer means the block is stuck
	always @(posedge clk) begin
		if (arst_n) begin
			if ((cmd_valid && cmd_ready) || (rsp_valid && rsp_ready)) idle_run = 0;
			else idle_run++;
			if (idle_run >= WATCHDOG_LIMIT) begin
				$display("watchdog: %0d cycles without a transfer, %0d answers outstanding",
					idle_run, answer_q.size());
				$display("grouped_permutation_enumerator_unit_tb NOT OK");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------

	initial begin
		model_reset();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_wrap_and_duplicates();
		test_count_extremes();
		test_group_boundaries();
		test_hidden_entries();
		test_random_phases();
		test_back_to_back();

		// drain, then give a late extra response time to show up
		settle(LATENCY_MAX);

		$display("covered %0d commands over %0d register settings", n_sent, n_settings);
		$display("answers: %0d advanced, %0d wrapped, %0d restarted, %0d loaded; %0d mismatches",
			n_advanced, n_wrapped, n_restarted, n_loaded, mismatches);
		if (mismatches == 0) begin
			$display("grouped_permutation_enumerator_unit_tb OK");
		end else begin
			$display("grouped_permutation_enumerator_unit_tb NOT OK");
		end
		$finish;
	end

endmodule

>>> sim.f
src/gpe_pkg.sv
src/gpe_store.sv
src/gpe_ctrl.sv
src/grouped_permutation_enumerator_unit.sv
src/gpe_checker.sv
tb/sv/grouped_permutation_enumerator_unit_tb.sv
